// ----- design/mpfa_pkg.sv -----
// shared types, sizes and codes of the montgomery prime-field alu
package mpfa_pkg;

    localparam int LIMB_W   = 64;
    localparam int LIMB_CNT = 4;
    localparam int TOP_W    = 63;
    localparam int OP_W     = LIMB_W * LIMB_CNT;
    localparam int DIG_W    = 32;
    localparam int DIG_CNT  = OP_W / DIG_W;
    localparam int ACC_W    = 2 * OP_W + 1;
    localparam int ADDR_W   = 6;

    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_SUB  = 3'd1;
    localparam logic [2:0] FN_NEG  = 3'd2;
    localparam logic [2:0] FN_MUL  = 3'd3;
    localparam logic [2:0] FN_SQR  = 3'd4;
    localparam logic [2:0] FN_FROM = 3'd5;

    localparam logic [2:0] REG_MOD0 = 3'd0;
    localparam logic [2:0] REG_MOD1 = 3'd1;
    localparam logic [2:0] REG_MOD2 = 3'd2;
    localparam logic [2:0] REG_MOD3 = 3'd3;
    localparam logic [2:0] REG_NINV = 3'd4;

    typedef struct packed {
        logic [2:0]        func;
        logic [LIMB_W-1:0] a_limb0;
        logic [LIMB_W-1:0] a_limb1;
        logic [LIMB_W-1:0] a_limb2;
        logic [LIMB_W-1:0] a_limb3;
        logic [LIMB_W-1:0] b_limb0;
        logic [LIMB_W-1:0] b_limb1;
        logic [LIMB_W-1:0] b_limb2;
        logic [LIMB_W-1:0] b_limb3;
    } t_in_word;

    typedef struct packed {
        logic [LIMB_W-1:0] result_limb0;
        logic [LIMB_W-1:0] result_limb1;
        logic [LIMB_W-1:0] result_limb2;
        logic [LIMB_W-1:0] result_limb3;
        logic              result_is_zero;
    } t_out_word;

    // word context that travels down the pipeline
    typedef struct packed {
        logic            vld;
        logic [2:0]      func;
        logic [OP_W-1:0] opa;
        logic [OP_W-1:0] opb;
        logic [OP_W:0]   lin;
    } t_ctx;

endpackage

// ----- design/mpfa_mac_row.sv -----
// two-stage row multiply-accumulate: acc + x * y, x one limb, y a full operand
module mpfa_mac_row (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mpfa_pkg::t_ctx             i_ctx,
    input  logic [mpfa_pkg::LIMB_W-1:0] i_x,
    input  logic [mpfa_pkg::OP_W-1:0]   i_y,
    input  logic [mpfa_pkg::ACC_W-1:0]  i_acc,
    output mpfa_pkg::t_ctx             o_ctx,
    output logic [mpfa_pkg::ACC_W-1:0]  o_acc
);
    import mpfa_pkg::*;

    logic [2*DIG_W-1:0] r_pp [2][DIG_CNT];
    logic [ACC_W-1:0]   r_acc_a;
    logic [ACC_W-1:0]   r_acc_b;
    logic [ACC_W-1:0]   n_acc;
    logic [ACC_W-1:0]   w_vec;
    t_ctx               r_ctx_a;
    t_ctx               r_ctx_b;

    // stage a: 32x32 partial products
    always_ff @(posedge i_clk) begin
        for (int h = 0; h < 2; h++) begin
            for (int d = 0; d < DIG_CNT; d++) begin
                r_pp[h][d] <= i_x[h*DIG_W +: DIG_W] * i_y[d*DIG_W +: DIG_W];
            end
        end
        r_acc_a <= i_acc;
    end

    // stage b: partials of equal parity do not overlap, four vectors plus acc
    always_comb begin
        n_acc = r_acc_a;
        w_vec = '0;
        for (int h = 0; h < 2; h++) begin
            for (int e = 0; e < 2; e++) begin
                w_vec = '0;
                for (int d = e; d < DIG_CNT; d += 2) begin
                    w_vec[(d+h)*DIG_W +: 2*DIG_W] = r_pp[h][d];
                end
                n_acc = n_acc + w_vec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_b <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_a.vld <= 1'b0;
            r_ctx_b.vld <= 1'b0;
        end else begin
            r_ctx_a <= i_ctx;
            r_ctx_b <= r_ctx_a;
        end
    end

    assign o_ctx = r_ctx_b;
    assign o_acc = r_acc_b;

endmodule

// ----- design/montgomery_prime_field_alu.sv -----
// top level of the pipelined prime-field alu with montgomery multiply
// each accepted word has its result strobed on o_done at the end of the pipeline;
//   throughput is one word per cycle
// the four product rows and four reduction rows are each their own pipeline stages
// busy stays low, the receiver takes every result as it comes
// reset (synchronous, active low) clears all valid bits and config registers to zero
module montgomery_prime_field_alu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mpfa_pkg::t_in_word          i_in,
    output logic                        o_done,
    output mpfa_pkg::t_out_word         o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpfa_pkg::ADDR_W-1:0] paddr,
    input  logic [mpfa_pkg::LIMB_W-1:0] pwdata,
    output logic [mpfa_pkg::LIMB_W-1:0] prdata,
    output logic                        pready
);
    import mpfa_pkg::*;

    localparam int LATENCY = 25;

    typedef struct packed {
        logic          vld;
        logic [2:0]    func;
        logic [OP_W:0] v;
        logic [OP_W:0] d;
    } t_fin;

    // configuration registers
    logic [LIMB_W-1:0] r_mod0;
    logic [LIMB_W-1:0] r_mod1;
    logic [LIMB_W-1:0] r_mod2;
    logic [TOP_W-1:0]  r_mod3;
    logic [LIMB_W-1:0] r_ninv;
    logic              w_wr;
    logic [2:0]        w_idx;
    logic [OP_W-1:0]   w_p;

    // front stages
    logic w_accept;
    t_ctx r_s0;
    t_ctx n_s0;
    t_ctx r_l1;
    t_ctx n_l1;
    t_ctx r_l2;
    t_ctx n_l2;

    // row chains
    t_ctx             w_pctx [LIMB_CNT+1];
    logic [ACC_W-1:0] w_pacc [LIMB_CNT+1];
    t_ctx             w_rctx [LIMB_CNT+1];
    logic [ACC_W-1:0] w_racc [LIMB_CNT+1];

    // back stages
    t_fin      r_f1;
    t_fin      n_f1;
    t_out_word n_out;
    t_out_word r_out;
    logic      r_done;
    logic [OP_W-1:0] w_res;

    // ---------------------------------------------------------------- apb port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[ADDR_W-1:3];
    // top limb keeps only 63 bits, so p stays below 2^255
    assign w_p    = {1'b0, r_mod3, r_mod2, r_mod1, r_mod0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod0 <= '0;
            r_mod1 <= '0;
            r_mod2 <= '0;
            r_mod3 <= '0;
            r_ninv <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MOD0: r_mod0 <= pwdata;
                REG_MOD1: r_mod1 <= pwdata;
                REG_MOD2: r_mod2 <= pwdata;
                REG_MOD3: r_mod3 <= pwdata[TOP_W-1:0];
                REG_NINV: r_ninv <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MOD0: prdata = r_mod0;
            REG_MOD1: prdata = r_mod1;
            REG_MOD2: prdata = r_mod2;
            REG_MOD3: prdata = {1'b0, r_mod3};
            REG_NINV: prdata = r_ninv;
            default:  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input stage
    // nothing ever holds the pipe, a word can enter every cycle
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_comb begin
        n_s0      = '0;
        n_s0.vld  = w_accept;
        n_s0.func = i_in.func;
        n_s0.opa  = {i_in.a_limb3, i_in.a_limb2, i_in.a_limb1, i_in.a_limb0};
        n_s0.opb  = {i_in.b_limb3, i_in.b_limb2, i_in.b_limb1, i_in.b_limb0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else begin
            r_s0 <= n_s0;
        end
    end

    // ---------------------------------------------------------------- linear ops
    // add keeps its carry in the top bit; sub and negate keep the borrow there.
    // the multiplier operand is picked here: b, a again for squaring, 1 to leave
    // montgomery form
    always_comb begin
        n_l1     = r_s0;
        n_l1.lin = '0;
        case (r_s0.func)
            FN_ADD: begin
                n_l1.lin = {1'b0, r_s0.opa} + {1'b0, r_s0.opb};
            end
            FN_SUB: begin
                n_l1.lin = {1'b0, r_s0.opa} - {1'b0, r_s0.opb};
            end
            FN_NEG: begin
                // zero minus zero has no borrow, so zero stays zero
                n_l1.lin = {(OP_W+1){1'b0}} - {1'b0, r_s0.opa};
            end
            FN_SQR: begin
                n_l1.opb = r_s0.opa;
            end
            FN_FROM: begin
                n_l1.opb = OP_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1.vld <= 1'b0;
        end else begin
            r_l1 <= n_l1;
        end
    end

    // add p back on borrow, modulo 2^256
    always_comb begin
        n_l2 = r_l1;
        if ((r_l1.func == FN_SUB || r_l1.func == FN_NEG) && r_l1.lin[OP_W]) begin
            n_l2.lin = {1'b0, r_l1.lin[OP_W-1:0] + w_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2.vld <= 1'b0;
        end else begin
            r_l2 <= n_l2;
        end
    end

    // ---------------------------------------------------------------- product rows
    // horner form from the top limb of a: row k does acc = (acc << 64) + a[3-k] * b
    assign w_pctx[0] = r_l2;
    assign w_pacc[0] = '0;

    for (genvar k = 0; k < LIMB_CNT; k++) begin : g_prod
        mpfa_mac_row u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctx   (w_pctx[k]),
            .i_x     (w_pctx[k].opa[(LIMB_CNT-1-k)*LIMB_W +: LIMB_W]),
            .i_y     (w_pctx[k].opb),
            .i_acc   ({w_pacc[k][ACC_W-LIMB_W-1:0], {LIMB_W{1'b0}}}),
            .o_ctx   (w_pctx[k+1]),
            .o_acc   (w_pacc[k+1])
        );
    end

    // ---------------------------------------------------------------- reduction rows
    // each row: m = t0 * ninv mod 2^64, t += m * p, then drop the zeroed low limb
    assign w_rctx[0] = w_pctx[LIMB_CNT];
    assign w_racc[0] = w_pacc[LIMB_CNT];

    for (genvar j = 0; j < LIMB_CNT; j++) begin : g_red
        logic [2*DIG_W-1:0] w_ml;
        logic [2*DIG_W-1:0] w_c1;
        logic [2*DIG_W-1:0] w_c2;
        logic [LIMB_W-1:0]  n_m;
        logic [LIMB_W-1:0]  r_m;
        logic [ACC_W-1:0]   r_macc;
        t_ctx               r_mctx;
        t_ctx               w_octx;
        logic [ACC_W-1:0]   w_oacc;

        // low half of the 64x64 product only needs three partials
        assign w_ml = w_racc[j][DIG_W-1:0] * r_ninv[DIG_W-1:0];
        assign w_c1 = w_racc[j][DIG_W-1:0] * r_ninv[LIMB_W-1:DIG_W];
        assign w_c2 = w_racc[j][LIMB_W-1:DIG_W] * r_ninv[DIG_W-1:0];
        assign n_m  = w_ml + {w_c1[DIG_W-1:0] + w_c2[DIG_W-1:0], {DIG_W{1'b0}}};

        always_ff @(posedge i_clk) begin
            r_m    <= n_m;
            r_macc <= w_racc[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mctx.vld <= 1'b0;
            end else begin
                r_mctx <= w_rctx[j];
            end
        end

        mpfa_mac_row u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctx   (r_mctx),
            .i_x     (r_m),
            .i_y     (w_p),
            .i_acc   (r_macc),
            .o_ctx   (w_octx),
            .o_acc   (w_oacc)
        );

        assign w_rctx[j+1] = w_octx;
        assign w_racc[j+1] = {{LIMB_W{1'b0}}, w_oacc[ACC_W-1:LIMB_W]};
    end

    // ---------------------------------------------------------------- final subtract
    // v carries one extra top bit: add carry or the top bit of the reduced value
    always_comb begin
        n_f1      = '0;
        n_f1.vld  = w_rctx[LIMB_CNT].vld;
        n_f1.func = w_rctx[LIMB_CNT].func;
        case (w_rctx[LIMB_CNT].func)
            FN_MUL, FN_SQR, FN_FROM: n_f1.v = w_racc[LIMB_CNT][OP_W:0];
            default:                 n_f1.v = w_rctx[LIMB_CNT].lin;
        endcase
        n_f1.d = {1'b0, n_f1.v[OP_W-1:0]} - {1'b0, w_p};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.vld <= 1'b0;
        end else begin
            r_f1 <= n_f1;
        end
    end

    // add and products take v - p if the extra bit is set or it did not borrow
    always_comb begin
        case (r_f1.func)
            FN_ADD, FN_MUL, FN_SQR, FN_FROM: begin
                w_res = (r_f1.v[OP_W] || !r_f1.d[OP_W]) ? r_f1.d[OP_W-1:0]
                                                        : r_f1.v[OP_W-1:0];
            end
            FN_SUB, FN_NEG: begin
                w_res = r_f1.v[OP_W-1:0];
            end
            default: begin
                w_res = '0;
            end
        endcase
        n_out.result_limb0   = w_res[0*LIMB_W +: LIMB_W];
        n_out.result_limb1   = w_res[1*LIMB_W +: LIMB_W];
        n_out.result_limb2   = w_res[2*LIMB_W +: LIMB_W];
        n_out.result_limb3   = w_res[3*LIMB_W +: LIMB_W];
        n_out.result_is_zero = (w_res == '0);
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_f1.vld;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    // ---------------------------------------------------------------- checks
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_done)
        else $error("accepted word did not complete on time");

    a_no_ghost : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LATENCY))
        else $error("result strobe without an accepted word");

    a_borrow_fixed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_l2.vld && (r_l2.func == FN_SUB || r_l2.func == FN_NEG)) |-> !r_l2.lin[OP_W])
        else $error("subtract borrow left after fix-up");

endmodule

// ----- bench/montgomery_prime_field_alu_tb.sv -----
// self-checking testbench of the montgomery prime-field alu: random and directed words
module montgomery_prime_field_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mpfa_pkg::*;

    localparam int PIPE_WAIT  = 40;    // a margin over the pipeline latency
    localparam int STALL_MAX  = 4000;  // cycles with nothing accepted or returned before giving up
    localparam int PHASE_WORDS = 260;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_word i_in = '0;
    logic o_done;
    t_out_word o_out;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [LIMB_W-1:0] pwdata = '0;
    logic [LIMB_W-1:0] prdata;
    logic pready;

    montgomery_prime_field_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_done(o_done), .o_out(o_out), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // bench copy of the configuration
    logic [OP_W-1:0]   cfg_mod = '0;
    logic [LIMB_W-1:0] cfg_ninv = '0;

    t_in_word  op_queue[$];     // words waiting to be driven
    t_out_word sum_queue[$];    // predicted results, oldest first
    int  sender_idle_pct = 0;
    bit  took = 1'b0;
    bit  failed = 1'b0;
    int  quiet_cycles = 0;

    // subtract p once when the extra bit is set or x is not below p
    function automatic logic [OP_W-1:0] reduce_once(logic [OP_W-1:0] x, logic extra);
        if (extra || x >= cfg_mod) return x - cfg_mod;
        return x;
    endfunction

    // word-serial redc, the accumulator wraps at nine limbs
    function automatic logic [OP_W-1:0] redc_wide(logic [575:0] acc);
        logic [575:0] m;
        logic [575:0] pw;
        pw = {320'd0, cfg_mod};
        for (int i = 0; i < LIMB_CNT; i++) begin
            m = {512'd0, acc[64*i +: 64] * cfg_ninv};
            acc = acc + ((m * pw) << (64 * i));
        end
        return reduce_once(acc[511:256], acc[575:512] != 0);
    endfunction

    function automatic t_out_word field_result(t_in_word w);
        logic [OP_W-1:0] a, b, r;
        logic [OP_W:0]   s;
        t_out_word o;
        a = {w.a_limb3, w.a_limb2, w.a_limb1, w.a_limb0};
        b = {w.b_limb3, w.b_limb2, w.b_limb1, w.b_limb0};
        r = '0;
        case (w.func)
            FN_ADD: begin
                s = {1'b0, a} + {1'b0, b};
                r = reduce_once(s[OP_W-1:0], s[OP_W]);
            end
            FN_SUB: begin
                r = a - b;
                if (a < b) r = r + cfg_mod;
            end
            FN_NEG: r = (a == 0) ? '0 : cfg_mod - a;
            FN_MUL: r = redc_wide({320'd0, a} * {320'd0, b});
            FN_SQR: r = redc_wide({320'd0, a} * {320'd0, a});
            FN_FROM: r = redc_wide({320'd0, a});
            default: r = '0;  // unused selectors give zero
        endcase
        o.result_limb0 = r[63:0];
        o.result_limb1 = r[127:64];
        o.result_limb2 = r[191:128];
        o.result_limb3 = r[255:192];
        o.result_is_zero = (r == 0);
        return o;
    endfunction

    function automatic t_in_word pack_word(logic [2:0] fn, logic [OP_W-1:0] a,
                                           logic [OP_W-1:0] b);
        t_in_word w;
        w.func = fn;
        {w.a_limb3, w.a_limb2, w.a_limb1, w.a_limb0} = a;
        {w.b_limb3, w.b_limb2, w.b_limb1, w.b_limb0} = b;
        return w;
    endfunction

    function automatic logic [OP_W-1:0] rand_wide();
        logic [OP_W-1:0] v;
        for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // mostly reduced operands, with edge values and unreduced noise mixed in
    function automatic logic [OP_W-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return '0;
            1: return 256'd1;
            2: return cfg_mod - 1;
            3: return cfg_mod;
            4: return '1;
            5: return rand_wide();
            default: return (cfg_mod == 0) ? rand_wide() : rand_wide() % cfg_mod;
        endcase
    endfunction

    // -p^-1 mod 2^64 by newton iteration
    function automatic logic [63:0] neg_inv64(logic [63:0] p0);
        logic [63:0] x;
        x = p0;
        for (int i = 0; i < 6; i++) x = x * (64'd2 - p0 * x);
        return -x;
    endfunction

    // driver: one word per falling edge unless idle; start held while a word waits
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (op_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_in <= op_queue.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predicts on acceptance, checks each strobed result
    always @(posedge i_clk) begin
        t_out_word want;
        took <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) begin
                sum_queue.push_back(field_result(i_in));
            end
            if (o_done) begin
                if (sum_queue.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_out);
                    failed = 1'b1;
                end else begin
                    want = sum_queue.pop_front();
                    if (o_out !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, o_out);
                        failed = 1'b1;
                    end
                end
            end
            // watchdog on cycles where nothing moves
            if ((start && !busy) || o_done) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= STALL_MAX) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MOD0: cfg_mod[63:0] = val;
            REG_MOD1: cfg_mod[127:64] = val;
            REG_MOD2: cfg_mod[191:128] = val;
            REG_MOD3: cfg_mod[255:192] = {1'b0, val[TOP_W-1:0]};
            default: cfg_ninv = val;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_modulus(logic [OP_W-1:0] p, logic [63:0] top_noise,
                               logic [63:0] ninv);
        reg_write(REG_MOD0, p[63:0]);
        reg_write(REG_MOD1, p[127:64]);
        reg_write(REG_MOD2, p[191:128]);
        // bit 63 of the top limb is dropped by the register
        reg_write(REG_MOD3, p[255:192] | top_noise);
        reg_write(REG_NINV, ninv);
    endtask

    task automatic drain();
        wait (op_queue.size() == 0 && !start);
        wait (sum_queue.size() == 0);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic random_words(int n);
        for (int i = 0; i < n; i++)
            op_queue.push_back(pack_word(3'($urandom_range(0, 7)), pick_operand(),
                                         pick_operand()));
    endtask

    initial begin
        logic [OP_W-1:0] p;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at reset: zero modulus
        sender_idle_pct = 11;
        op_queue.push_back(pack_word(FN_ADD, '1, 256'd5));
        op_queue.push_back(pack_word(FN_SUB, 256'd0, 256'd1));
        op_queue.push_back(pack_word(FN_MUL, '1, '1));
        op_queue.push_back(pack_word(FN_FROM, 256'd7, '0));
        drain();

        // directed words on 2^255 - 19
        p = (256'd1 << 255) - 19;
        set_modulus(p, 64'd1 << 63, neg_inv64(p[63:0]));
        op_queue.push_back(pack_word(FN_ADD, p - 1, p - 1));
        op_queue.push_back(pack_word(FN_ADD, '0, '0));
        op_queue.push_back(pack_word(FN_ADD, '1, '1));
        op_queue.push_back(pack_word(FN_SUB, '0, 256'd1));
        op_queue.push_back(pack_word(FN_SUB, p - 1, p - 1));
        op_queue.push_back(pack_word(FN_SUB, '0, '1));
        op_queue.push_back(pack_word(FN_NEG, '0, '1));
        op_queue.push_back(pack_word(FN_NEG, 256'd1, '0));
        op_queue.push_back(pack_word(FN_NEG, p - 1, '0));
        op_queue.push_back(pack_word(FN_NEG, '1, '0));
        op_queue.push_back(pack_word(FN_MUL, 256'd1, 256'd1));
        op_queue.push_back(pack_word(FN_MUL, p - 1, p - 1));
        op_queue.push_back(pack_word(FN_MUL, '1, '1));
        op_queue.push_back(pack_word(FN_SQR, '1, '0));
        op_queue.push_back(pack_word(FN_SQR, '0, '1));
        op_queue.push_back(pack_word(FN_FROM, 256'd1, '0));
        op_queue.push_back(pack_word(FN_FROM, '0, '0));
        op_queue.push_back(pack_word(FN_FROM, '1, '1));
        op_queue.push_back(pack_word(3'd6, '1, '1));
        op_queue.push_back(pack_word(3'd7, '1, '1));
        random_words(PHASE_WORDS);
        drain();

        // largest modulus the registers hold
        p = {1'b0, {255{1'b1}}};
        set_modulus(p, '0, neg_inv64(p[63:0]));
        random_words(PHASE_WORDS);
        drain();

        // random odd modulus, sender slowed down
        sender_idle_pct = 65;
        p = rand_wide();
        p[0] = 1'b1;
        p[255] = 1'b0;
        set_modulus(p, '0, neg_inv64(p[63:0]));
        random_words(PHASE_WORDS);
        drain();

        // broken setup: any modulus, any reduction factor
        p = rand_wide();
        set_modulus(p, {$urandom, $urandom}, {$urandom, $urandom});
        random_words(PHASE_WORDS);
        drain();

        // small odd modulus, no idling
        sender_idle_pct = 0;
        p = {224'd0, $urandom} | 256'd1;
        set_modulus(p, '0, neg_inv64(p[63:0]));
        random_words(PHASE_WORDS);
        drain();

        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- montgomery_prime_field_alu.f -----
design/mpfa_pkg.sv
design/mpfa_mac_row.sv
design/montgomery_prime_field_alu.sv
bench/montgomery_prime_field_alu_tb.sv
